[design/tmh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tmh_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CH_W   = ADDR_W + 2;

    localparam int DIV3_SH  = ADDR_W + 1;
    localparam int DIV3_MUL = (2 ** DIV3_SH) / 3 + 1;
    localparam int PROD_W   = ADDR_W + DIV3_SH;

    localparam int IN_USER_W = 2;
    localparam int IN_DATA_W = ((KEY_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS  = KEY_WIDTH + 1 + CNT_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_READ_PARENT,
        DP_MOVE_UP,
        DP_WRITE_KEY,
        DP_LOAD_LAST,
        DP_READ_CHILD,
        DP_CMP_CHILD,
        DP_MOVE_DOWN,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] kind;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic cnt_one;
        logic pos_zero;
        logic key_gt;
        logic child_ok;
        logic best_at_pos;
    } t_dp_stat;

endpackage

`default_nettype wire

[design/ternary_max_heap_top.sv]
// Max priority queue of signed keys held as a 3-ary heap in one single-port-read, registered
// memory of CAPACITY entries. Each input beat is a command (push, pop or peek; the spare code acts
// as a peek) and yields one output beat with the top key (all ones when empty), the empty flag,
// the entry count and the overflow flag of a dropped push. One command is worked at a time; the
// memory's single registered read port sets the pace. A peek, a dropped push or a pop on a heap
// of at most one entry goes straight to its result; a push reads one parent per level that the
// key climbs; a pop reads the last entry, then reads and compares each child and moves the
// entry down a level at a time. A new command is taken while the previous result waits at the
// output.
`timescale 1ns / 1ps
`default_nettype none

module ternary_max_heap_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // key_in
    input  wire logic [tmh_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // cmd
    input  wire logic [tmh_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // top_key, is_empty, entry_count, overflow, zero pad
    output logic [tmh_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata
);
    import tmh_pkg::*;

    t_dp_cmd                     w_cmd;
    t_dp_stat                    w_stat;
    logic signed [KEY_WIDTH-1:0] w_top_key;
    logic                        w_is_empty;
    logic [CNT_W-1:0]            w_entry_count;
    logic                        w_overflow;

    tmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_kind   (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tmh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_key         (i_s_axis_tdata[KEY_WIDTH-1:0]),
        .o_stat        (w_stat),
        .o_top_key     (w_top_key),
        .o_is_empty    (w_is_empty),
        .o_entry_count (w_entry_count),
        .o_overflow    (w_overflow)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({w_overflow, w_entry_count, w_is_empty, w_top_key});

endmodule

`default_nettype wire

[design/tmh_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tmh_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_kind,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire tmh_pkg::t_dp_stat i_stat,
    output tmh_pkg::t_dp_cmd       o_cmd
);
    import tmh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_WAIT,
        S_DN_LAST,
        S_DN_CHECK,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NONE;
        o_cmd.kind = i_in_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_ACCEPT;
                    case (t_cmd'(i_in_kind))
                        CMD_PUSH: n_state = i_stat.full ? S_DONE : S_UP_CHECK;
                        CMD_POP: begin
                            if (i_stat.empty || i_stat.cnt_one) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_DN_LAST;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_UP_CHECK: begin
                if (i_stat.pos_zero) begin
                    o_cmd.op = DP_WRITE_KEY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = DP_READ_PARENT;
                    n_state  = S_UP_WAIT;
                end
            end
            S_UP_WAIT: begin
                if (i_stat.key_gt) begin
                    o_cmd.op = DP_MOVE_UP;
                    n_state  = S_UP_CHECK;
                end else begin
                    o_cmd.op = DP_WRITE_KEY;
                    n_state  = S_DONE;
                end
            end
            S_DN_LAST: begin
                o_cmd.op = DP_LOAD_LAST;
                n_state  = S_DN_CHECK;
            end
            S_DN_CHECK: begin
                if (i_stat.child_ok) begin
                    o_cmd.op = DP_READ_CHILD;
                    n_state  = S_DN_CMP;
                end else if (i_stat.best_at_pos) begin
                    o_cmd.op = DP_WRITE_KEY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = DP_MOVE_DOWN;
                end
            end
            S_DN_CMP: begin
                o_cmd.op = DP_CMP_CHILD;
                n_state  = S_DN_CHECK;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[design/tmh_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module tmh_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tmh_pkg::t_dp_cmd                    i_cmd,
    input  wire logic signed [tmh_pkg::KEY_WIDTH-1:0] i_key,
    output tmh_pkg::t_dp_stat                        o_stat,
    output logic signed [tmh_pkg::KEY_WIDTH-1:0]     o_top_key,
    output logic                                     o_is_empty,
    output logic [tmh_pkg::CNT_W-1:0]                o_entry_count,
    output logic                                     o_overflow
);
    import tmh_pkg::*;

    logic signed [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic signed [KEY_WIDTH-1:0] r_rdata;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] r_top;
    logic signed [KEY_WIDTH-1:0] r_best_val;
    logic [ADDR_W-1:0]           r_pos;
    logic [ADDR_W-1:0]           r_par;
    logic [ADDR_W-1:0]           r_best_idx;
    logic [CH_W-1:0]             r_child;
    logic [1:0]                  r_nchild;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_ovf;

    logic                        w_we;
    logic [ADDR_W-1:0]           w_wa;
    logic signed [KEY_WIDTH-1:0] w_wd;
    logic                        w_re;
    logic [ADDR_W-1:0]           w_ra;
    logic [ADDR_W-1:0]           w_pm1;
    logic [PROD_W-1:0]           w_prod;
    logic [ADDR_W-1:0]           w_par;
    logic [CH_W-1:0]             w_next_child;
    logic                        w_is_push;
    logic                        w_is_pop;

    assign w_is_push = (i_cmd.kind == CMD_PUSH);
    assign w_is_pop  = (i_cmd.kind == CMD_POP);

    assign w_pm1  = r_pos - ADDR_W'(1);
    assign w_prod = PROD_W'(w_pm1) * PROD_W'(DIV3_MUL);
    assign w_par  = w_prod[DIV3_SH +: ADDR_W];

    assign w_next_child = (CH_W'(r_best_idx) << 1) + CH_W'(r_best_idx) + CH_W'(1);

    assign o_stat.full        = (r_cnt == CNT_W'(CAPACITY));
    assign o_stat.empty       = (r_cnt == '0);
    assign o_stat.cnt_one     = (r_cnt == CNT_W'(1));
    assign o_stat.pos_zero    = (r_pos == '0);
    assign o_stat.key_gt      = (r_key > r_rdata);
    assign o_stat.child_ok    = (r_nchild != 2'd3) && (r_child < CH_W'(r_cnt));
    assign o_stat.best_at_pos = (r_best_idx == r_pos);

    always_comb begin
        w_we = 1'b0;
        w_wa = r_pos;
        w_wd = r_key;
        w_re = 1'b0;
        w_ra = r_par;
        case (i_cmd.op)
            DP_ACCEPT: begin
                w_re = w_is_pop && (r_cnt != '0);
                w_ra = ADDR_W'(r_cnt - CNT_W'(1));
            end
            DP_READ_PARENT: begin
                w_re = 1'b1;
                w_ra = w_par;
            end
            DP_READ_CHILD: begin
                w_re = 1'b1;
                w_ra = r_child[ADDR_W-1:0];
            end
            DP_MOVE_UP: begin
                w_we = 1'b1;
                w_wd = r_rdata;
            end
            DP_WRITE_KEY: w_we = 1'b1;
            DP_MOVE_DOWN: begin
                w_we = 1'b1;
                w_wd = r_best_val;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            o_is_empty <= 1'b1;
        end else begin
            case (i_cmd.op)
                DP_ACCEPT: begin
                    r_key <= i_key;
                    r_ovf <= w_is_push && o_stat.full;
                    if (w_is_push && !o_stat.full) begin
                        r_pos <= r_cnt[ADDR_W-1:0];
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (w_is_pop && !o_stat.empty) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                DP_READ_PARENT: r_par <= w_par;
                DP_MOVE_UP:     r_pos <= r_par;
                DP_WRITE_KEY: begin
                    if (r_pos == '0) begin
                        r_top <= r_key;
                    end
                end
                DP_LOAD_LAST: begin
                    r_key      <= r_rdata;
                    r_best_val <= r_rdata;
                    r_pos      <= '0;
                    r_best_idx <= '0;
                    r_child    <= CH_W'(1);
                    r_nchild   <= 2'd0;
                end
                DP_CMP_CHILD: begin
                    if (r_rdata > r_best_val) begin
                        r_best_val <= r_rdata;
                        r_best_idx <= r_child[ADDR_W-1:0];
                    end
                    r_child  <= r_child + CH_W'(1);
                    r_nchild <= r_nchild + 2'd1;
                end
                DP_MOVE_DOWN: begin
                    if (r_pos == '0) begin
                        r_top <= r_best_val;
                    end
                    r_pos      <= r_best_idx;
                    r_best_val <= r_key;
                    r_child    <= w_next_child;
                    r_nchild   <= 2'd0;
                end
                DP_OUT: begin
                    o_top_key     <= o_stat.empty ? '1 : r_top;
                    o_is_empty    <= o_stat.empty;
                    o_entry_count <= r_cnt;
                    o_overflow    <= r_ovf;
                end
                default: r_ovf <= r_ovf;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CNT_W'(r_pos) < r_cnt))
        else $error("write outside filled region");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_ACCEPT && w_is_push && !o_stat.full)
        |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("push did not grow the heap");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> o_stat.full)
        else $error("overflow flagged on a heap with room");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    import tmh_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         TAIL_CYCLES = 40;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] top_key;
        logic                 is_empty;
        logic [CNT_W-1:0]     entry_count;
        logic                 overflow;
    } t_heap_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // key_in
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    // cmd
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // top_key, is_empty, entry_count, overflow, zero pad
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    logic signed [KEY_WIDTH-1:0] heap_keys [CAPACITY];
    int unsigned                 heap_fill;
    t_heap_result                pending_results [$];
    int                          mismatch_count;
    int                          cycle_count = 0;
    bit                          steady_tail;

    ternary_max_heap_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_heap_result heap_apply(logic [1:0] cmd,
                                                logic signed [KEY_WIDTH-1:0] key);
        t_heap_result                res;
        logic signed [KEY_WIDTH-1:0] tmp;
        int unsigned                 pos;
        int unsigned                 par;
        int unsigned                 best;
        int unsigned                 child;
        res = '0;
        if (cmd == CMD_PUSH) begin
            if (heap_fill >= CAPACITY) begin
                res.overflow = 1'b1;
            end else begin
                pos = heap_fill;
                heap_keys[pos] = key;
                heap_fill++;
                while (pos > 0) begin
                    par = (pos - 1) / 3;
                    if (!(heap_keys[pos] > heap_keys[par])) break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[par];
                    heap_keys[par] = tmp;
                    pos = par;
                end
            end
        end else if (cmd == CMD_POP && heap_fill > 0) begin
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            pos = 0;
            while (1) begin
                best = pos;
                for (int c = 1; c <= 3; c++) begin
                    child = pos * 3 + c;
                    if (child >= heap_fill) break;
                    if (heap_keys[child] > heap_keys[best]) best = child;
                end
                if (best == pos) break;
                tmp = heap_keys[pos];
                heap_keys[pos] = heap_keys[best];
                heap_keys[best] = tmp;
                pos = best;
            end
        end
        res.top_key     = (heap_fill == 0) ? '1 : heap_keys[0];
        res.is_empty    = (heap_fill == 0);
        res.entry_count = heap_fill[CNT_W-1:0];
        return res;
    endfunction

    function automatic logic signed [KEY_WIDTH-1:0] random_key();
        logic signed [KEY_WIDTH-1:0] k;
        case ($urandom_range(0, 7))
            0, 1, 2: k = $urandom;
            3, 4, 5: k = $signed($urandom_range(0, 8)) - 4;
            6: begin
                case ($urandom_range(0, 3))
                    0: k = {1'b0, {(KEY_WIDTH-1){1'b1}}};
                    1: k = {1'b1, {(KEY_WIDTH-1){1'b0}}};
                    2: k = '0;
                    default: k = '1;
                endcase
            end
            default: k = $signed($urandom_range(0, 2000)) - 1000;
        endcase
        return k;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic signed [KEY_WIDTH-1:0] key);
        t_heap_result want;
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'(key);
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        want = heap_apply(cmd, key);
        pending_results = {pending_results, want};
    endtask

    task automatic test_empty_heap();
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_SPARE, 32'sd77);
    endtask

    task automatic test_key_extremes();
        send_cmd(CMD_PUSH, {1'b1, {(KEY_WIDTH-1){1'b0}}});
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_PUSH, {1'b0, {(KEY_WIDTH-1){1'b1}}});
        send_cmd(CMD_PUSH, {1'b1, {(KEY_WIDTH-1){1'b0}}});
        send_cmd(CMD_PUSH, '1);
        send_cmd(CMD_PUSH, '0);
        send_cmd(CMD_PUSH, 32'sd1);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_POP, '0);
    endtask

    task automatic test_equal_keys();
        repeat (4) send_cmd(CMD_PUSH, 32'sd9);
        send_cmd(CMD_PUSH, -32'sd2);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_SPARE, '0);
        send_cmd(CMD_POP, '0);
        repeat (8) send_cmd(CMD_POP, '0);
    endtask

    task automatic test_random_mix(int count, int pop_weight);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < pop_weight)
                send_cmd(CMD_POP, random_key());
            else if (r < pop_weight + 10)
                send_cmd(CMD_PEEK, random_key());
            else if (r < pop_weight + 15)
                send_cmd(CMD_SPARE, random_key());
            else
                send_cmd(CMD_PUSH, random_key());
        end
    endtask

    task automatic test_fill_to_capacity();
        while (heap_fill < CAPACITY) begin
            if ($urandom_range(0, 19) == 0)
                send_cmd(CMD_PEEK, random_key());
            else
                send_cmd(CMD_PUSH, random_key());
        end
        repeat (3) send_cmd(CMD_PUSH, random_key());
        send_cmd(CMD_PEEK, random_key());
        send_cmd(CMD_PUSH, random_key());
        send_cmd(CMD_POP, random_key());
        send_cmd(CMD_PUSH, random_key());
        send_cmd(CMD_PUSH, random_key());
    endtask

    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            if (steady_tail) begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_heap_result want;
        t_heap_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.top_key     = o_m_axis_tdata[KEY_WIDTH-1:0];
            got.is_empty    = o_m_axis_tdata[KEY_WIDTH];
            got.entry_count = o_m_axis_tdata[KEY_WIDTH+1 +: CNT_W];
            got.overflow    = o_m_axis_tdata[KEY_WIDTH+1+CNT_W];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 64'(o_m_axis_tdata), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.top_key != want.top_key)
                    report_mismatch("top_key", 64'(got.top_key), 64'(want.top_key));
                if (got.is_empty != want.is_empty)
                    report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
                if (got.entry_count != want.entry_count)
                    report_mismatch("entry_count", 64'(got.entry_count),
                                    64'(want.entry_count));
                if (got.overflow != want.overflow)
                    report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL ternary_max_heap_top");
            $finish;
        end
    end

    initial begin
        mismatch_count  = 0;
        heap_fill       = 0;
        steady_tail     = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_heap();
        test_key_extremes();
        test_equal_keys();
        test_random_mix(100, 35);
        test_fill_to_capacity();
        test_random_mix(60, 60);
        steady_tail = 1'b1;
        test_random_mix(60, 45);
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS ternary_max_heap_top");
        else
            $display("FAIL ternary_max_heap_top");
        $finish;
    end

endmodule
